[sv/photometric_normal_pixel_defines.svh]
// assertion macros for the photometric normal pixel block
// no dependencies; included by files that carry assertions
`ifndef PHOTOMETRIC_NORMAL_PIXEL_DEFINES_SVH
`define PHOTOMETRIC_NORMAL_PIXEL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PNP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pnp assertion failed");
`define PNP_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pnp assertion failed");
`else
`define PNP_ASSERT(label, clk, rst, prop)
`define PNP_ASSERT_NR(label, clk, prop)
`endif
`endif

[sv/pnp_pkg.sv]
// shared types, constants and step functions of the photometric normal pixel
// no dependencies
`default_nettype none
package pnp_pkg;
   localparam int SW  = 21;   // width of squared magnitude
   localparam int QW  = 52;   // width of quotient 2^50/s, one pad bit on top
   localparam int RTW = 26;   // width of square root result
   localparam int RMW = 27;   // width of square root remainder
   localparam logic [7:0] THRESH_RESET = 8'd40;

   typedef struct packed {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic signed [11:0] z;
      logic               zero;
   } side_type;

   typedef struct packed {
      logic     valid;
      side_type side;
   } tag_type;

   // one restoring division step: returns {quotient bit, remainder}
   function automatic logic [SW:0] div_step(input logic [SW-1:0] rem,
                                            input logic bit_in,
                                            input logic [SW-1:0] d);
      logic [SW:0] t;
      t = {rem, bit_in};
      if (t >= {1'b0, d}) begin
         div_step = {1'b1, SW'(t - {1'b0, d})};
      end else begin
         div_step = {1'b0, t[SW-1:0]};
      end
   endfunction

   // one digit of the square root: returns {root, remainder}
   function automatic logic [RTW+RMW-1:0] sqrt_step(input logic [RMW-1:0] rem,
                                                   input logic [RTW-1:0] root,
                                                   input logic [1:0] pair);
      logic [RMW+1:0] t;
      logic [RMW+1:0] trial;
      t     = {rem, pair};
      trial = {1'b0, root, 2'b01};
      if (t >= trial) begin
         sqrt_step = {root[RTW-2:0], 1'b1, RMW'(t - trial)};
      end else begin
         sqrt_step = {root[RTW-2:0], 1'b0, t[RMW-1:0]};
      end
   endfunction
endpackage
`default_nettype wire

[sv/pnp_req_if.sv]
// request channel: four intensities of one pixel
// no dependencies
`default_nettype none
interface pnp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] light_a;
   logic [7:0] light_b;
   logic [7:0] light_c;
   logic [7:0] light_d;
   modport source (output valid, light_a, light_b, light_c, light_d, input ready);
   modport sink (input valid, light_a, light_b, light_c, light_d, output ready);
endinterface
`default_nettype wire

[sv/pnp_rsp_if.sv]
// response channel: mapped unit normal of one pixel
// no dependencies
`default_nettype none
interface pnp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] normal_x;
   logic [7:0] normal_y;
   logic [7:0] normal_z;
   modport source (output valid, normal_x, normal_y, normal_z, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface
`default_nettype wire

[sv/pnp_front.sv]
// front stages: dark gating, normal vector, squared magnitude
// depends on pnp_pkg
`default_nettype none
module pnp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [7:0]        light_a,
   input  wire logic [7:0]        light_b,
   input  wire logic [7:0]        light_c,
   input  wire logic [7:0]        light_d,
   input  wire logic [7:0]        thresh,
   output pnp_pkg::tag_type       tag_out,
   output logic [pnp_pkg::SW-1:0] s_out
);
   import pnp_pkg::*;

   logic [7:0]  ga, gb, gc, gd;
   logic [11:0] xd, yd;
   tag_type     t1_ff, t1_in, t2_ff, t3_ff, t3_in;
   logic signed [23:0] xs, ys, zs;
   logic [19:0] sx_ff, sy_ff, sz_ff;
   logic [SW-1:0] s_ff, s_in;

   always_comb begin
      ga = (light_a < thresh) ? 8'd0 : light_a;
      gb = (light_b < thresh) ? 8'd0 : light_b;
      gc = (light_c < thresh) ? 8'd0 : light_c;
      gd = (light_d < thresh) ? 8'd0 : light_d;
      xd = {4'd0, ga} - {4'd0, gb};
      yd = {4'd0, gc} - {4'd0, gd};
      t1_in.valid     = in_valid;
      t1_in.side.x    = {xd[10:0], 1'b0};
      t1_in.side.y    = {yd[10:0], 1'b0};
      t1_in.side.z    = 12'({4'd0, ga} + {4'd0, gb} + {4'd0, gc} + {4'd0, gd});
      t1_in.side.zero = 1'b0;
      xs = t1_ff.side.x * t1_ff.side.x;
      ys = t1_ff.side.y * t1_ff.side.y;
      zs = t1_ff.side.z * t1_ff.side.z;
      s_in = SW'({1'b0, sx_ff} + {1'b0, sy_ff} + {1'b0, sz_ff});
      t3_in = t2_ff;
      t3_in.side.zero = (s_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
         t2_ff.valid <= 1'b0;
         t3_ff.valid <= 1'b0;
      end else if (en) begin
         t1_ff <= t1_in;
         t2_ff <= t1_ff;
         sx_ff <= xs[19:0];
         sy_ff <= ys[19:0];
         sz_ff <= zs[19:0];
         t3_ff <= t3_in;
         s_ff  <= s_in;
      end
   end

   assign tag_out = t3_ff;
   assign s_out   = s_ff;
endmodule
`default_nettype wire

[sv/pnp_div.sv]
// pipelined restoring divider computing floor(2^50 / s), two bits per stage
// depends on pnp_pkg
`default_nettype none
module pnp_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire pnp_pkg::tag_type  tag_in,
   input  wire logic [pnp_pkg::SW-1:0] s_in,
   output pnp_pkg::tag_type       tag_out,
   output logic [pnp_pkg::QW-1:0] q_out
);
   import pnp_pkg::*;

   localparam int NST = QW / 2;

   tag_type       tag_ff [NST];
   logic [SW-1:0] rem_ff [NST];
   logic [SW-1:0] d_ff   [NST];
   logic [QW-1:0] q_ff   [NST];

   for (genvar k = 0; k < NST; k++) begin : g_st
      tag_type       tag_src;
      logic [SW-1:0] rem_src, d_src;
      logic [QW-1:0] q_src;
      logic [SW:0]   st0, st1;

      if (k == 0) begin : g_first
         assign tag_src = tag_in;
         assign rem_src = '0;
         assign d_src   = s_in;
         assign q_src   = '0;
      end else begin : g_next
         assign tag_src = tag_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign d_src   = d_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      // numerator is a single one at bit 50, i.e. the second step overall
      always_comb begin
         st0 = div_step(rem_src, 1'b0, d_src);
         st1 = div_step(st0[SW-1:0], (k == 0), d_src);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (en) begin
            tag_ff[k] <= tag_src;
            rem_ff[k] <= st1[SW-1:0];
            d_ff[k]   <= d_src;
            q_ff[k]   <= {q_src[QW-3:0], st0[SW], st1[SW]};
         end
      end
   end

   assign tag_out = tag_ff[NST-1];
   assign q_out   = q_ff[NST-1];
endmodule
`default_nettype wire

[sv/pnp_isqrt.sv]
// pipelined digit-by-digit integer square root, two digits per stage
// depends on pnp_pkg
`default_nettype none
module pnp_isqrt (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire pnp_pkg::tag_type   tag_in,
   input  wire logic [pnp_pkg::QW-1:0] q_in,
   output pnp_pkg::tag_type        tag_out,
   output logic [pnp_pkg::RTW-1:0] root_out
);
   import pnp_pkg::*;

   localparam int NST = QW / 4;

   tag_type        tag_ff  [NST];
   logic [RMW-1:0] rem_ff  [NST];
   logic [RTW-1:0] root_ff [NST];
   logic [QW-1:0]  q_ff    [NST];

   for (genvar k = 0; k < NST; k++) begin : g_st
      tag_type        tag_src;
      logic [RMW-1:0] rem_src;
      logic [RTW-1:0] root_src;
      logic [QW-1:0]  q_src;
      logic [RTW+RMW-1:0] st0, st1;

      if (k == 0) begin : g_first
         assign tag_src  = tag_in;
         assign rem_src  = '0;
         assign root_src = '0;
         assign q_src    = q_in;
      end else begin : g_next
         assign tag_src  = tag_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign q_src    = q_ff[k-1];
      end

      always_comb begin
         st0 = sqrt_step(rem_src, root_src, q_src[QW-1:QW-2]);
         st1 = sqrt_step(st0[RMW-1:0], st0[RTW+RMW-1:RMW], q_src[QW-3:QW-4]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k].valid <= 1'b0;
         end else if (en) begin
            tag_ff[k]  <= tag_src;
            rem_ff[k]  <= st1[RMW-1:0];
            root_ff[k] <= st1[RTW+RMW-1:RMW];
            q_ff[k]    <= {q_src[QW-5:0], 4'd0};
         end
      end
   end

   assign tag_out  = tag_ff[NST-1];
   assign root_out = root_ff[NST-1];
endmodule
`default_nettype wire

[sv/pnp_map.sv]
// rounding of the reciprocal root, scaling of each component, output register
// depends on pnp_pkg
`default_nettype none
module pnp_map (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire pnp_pkg::tag_type   tag_in,
   input  wire logic [pnp_pkg::RTW-1:0] root_in,
   output logic                    out_valid,
   output logic [7:0]              normal_x,
   output logic [7:0]              normal_y,
   output logic [7:0]              normal_z
);
   import pnp_pkg::*;

   tag_type        t1_ff, t2_ff;
   logic [RTW-1:0] rr_ff, rr_in;
   logic signed [38:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic valid_ff;
   logic [7:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;

   function automatic logic [7:0] scale(input logic signed [38:0] p, input logic zero);
      logic signed [47:0] num;
      logic signed [47:0] q;
      num = (48'(p) <<< 8) - 48'(p) + (48'sd1 <<< 32);
      q   = num >>> 25;
      if (zero || num < 0) begin
         scale = 8'd0;
      end else if (q > 48'sd255) begin
         scale = 8'd255;
      end else begin
         scale = q[7:0];
      end
   endfunction

   always_comb begin
      rr_in = RTW'(({1'b0, root_in} + 1'b1) >> 1);
      px_in = t1_ff.side.x * $signed({1'b0, rr_ff});
      py_in = t1_ff.side.y * $signed({1'b0, rr_ff});
      pz_in = t1_ff.side.z * $signed({1'b0, rr_ff});
      nx_in = scale(px_ff, t2_ff.side.zero);
      ny_in = scale(py_ff, t2_ff.side.zero);
      nz_in = scale(pz_ff, t2_ff.side.zero);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff.valid <= 1'b0;
         t2_ff.valid <= 1'b0;
         valid_ff    <= 1'b0;
      end else if (en) begin
         t1_ff    <= tag_in;
         rr_ff    <= rr_in;
         t2_ff    <= t1_ff;
         px_ff    <= px_in;
         py_ff    <= py_in;
         pz_ff    <= pz_in;
         valid_ff <= t2_ff.valid;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         nz_ff    <= nz_in;
      end
   end

   assign out_valid = valid_ff;
   assign normal_x  = nx_ff;
   assign normal_y  = ny_ff;
   assign normal_z  = nz_ff;
endmodule
`default_nettype wire

[sv/photometric_normal_pixel.sv]
// Four-light photometric stereo normal, one pixel per transaction.
// req_chan carries the four intensities of a pixel under lights at (1,0,1),
// (-1,0,1), (0,1,1) and (0,-1,1); rsp_chan returns the unit normal with each
// component mapped from [-1,1] to 0..255. csr_we/csr_wdata set the dark
// threshold; intensities below it count as zero. Write it while idle.
// From request transaction to response valid a pixel passes three front
// stages, 26 divider stages, 13 square root stages and three output
// stages. Throughput is one pixel per cycle while responses are taken; the
// divider and root each resolve two digits per stage.
// The whole pipeline advances as one: req_ready is high while the output
// register is empty or being taken, so a stalled receiver freezes every stage
// and no transaction is lost or repeated.
// Synchronous reset empties the pipeline and sets the threshold to 40.
// depends on pnp_pkg, pnp_req_if, pnp_rsp_if and the stage modules
`default_nettype none
`include "photometric_normal_pixel_defines.svh"
module photometric_normal_pixel (
   input  wire logic       clock,
   input  wire logic       reset,
   pnp_req_if.sink         req_chan,
   pnp_rsp_if.source       rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);
   import pnp_pkg::*;

   logic [7:0]     thresh_ff, thresh_in;
   logic           en;
   tag_type        f_tag, d_tag, r_tag;
   logic [SW-1:0]  s_w;
   logic [QW-1:0]  q_w;
   logic [RTW-1:0] root_w;

   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;
   assign thresh_in      = csr_we ? csr_wdata : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   pnp_front u_front (
      .clock, .reset, .en,
      .in_valid (req_chan.valid),
      .light_a  (req_chan.light_a),
      .light_b  (req_chan.light_b),
      .light_c  (req_chan.light_c),
      .light_d  (req_chan.light_d),
      .thresh   (thresh_ff),
      .tag_out  (f_tag),
      .s_out    (s_w)
   );

   pnp_div u_div (
      .clock, .reset, .en,
      .tag_in  (f_tag),
      .s_in    (s_w),
      .tag_out (d_tag),
      .q_out   (q_w)
   );

   pnp_isqrt u_isqrt (
      .clock, .reset, .en,
      .tag_in   (d_tag),
      .q_in     (q_w),
      .tag_out  (r_tag),
      .root_out (root_w)
   );

   pnp_map u_map (
      .clock, .reset, .en,
      .tag_in    (r_tag),
      .root_in   (root_w),
      .out_valid (rsp_chan.valid),
      .normal_x  (rsp_chan.normal_x),
      .normal_y  (rsp_chan.normal_y),
      .normal_z  (rsp_chan.normal_z)
   );

   `PNP_ASSERT(a_ready_follows_out, clock, reset, req_chan.ready == (!rsp_chan.valid || rsp_chan.ready))
   `PNP_ASSERT(a_csr_write, clock, reset, csr_we |=> thresh_ff == $past(csr_wdata))
   `PNP_ASSERT_NR(a_reset_empties, clock, reset |=> !rsp_chan.valid)
endmodule
`default_nettype wire
